/* rtl/tws_pkg.sv */
// ----------------------------------------------------------------------------
// tws_pkg - shared types and constants of the trie word store
// Node pool sizes, command codes, beat structs and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tws_pkg;

    // Node pool and alphabet
    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int FREE_W        = $clog2(MAX_NODES + 1);
    localparam int LINK_IDX_W    = $clog2(ALPHABET_SIZE);

    // Field widths of the item beat
    localparam int CMD_W    = 2;
    localparam int LETTER_W = 5;

    // Command codes; any other code acts as a prefix query
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_SEARCH = CMD_W'(1);

    // One input beat
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } tws_item_t;

    // One result beat
    typedef struct packed {
        logic found;
        logic pool_full;
    } tws_result_t;

    // One node row: a child link per letter, 0 meaning no child
    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] tws_row_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
        logic finish_load;
    } tws_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic item_last;
        logic out_free;
    } tws_stat_t;

endpackage

/* rtl/trie_word_store.sv */
// ----------------------------------------------------------------------------
// trie_word_store - 26-letter trie in a bounded node pool
// Top level: joins the sequencer and the node datapath.
// ----------------------------------------------------------------------------
// Words arrive one letter beat at a time with a command and a last-letter
// mark; one result beat follows each beat that carries the mark. After reset
// the block runs a clearing pass over all MAX_NODES (1024) rows of the link
// and end-mark memories, holding item_stall high. Then a letter beat takes
// an accept step with the node-row memory read, then the link decision and
// possible link write; a beat with the last mark adds a finish step for the
// end-mark memory read and write and the load of the result register, which
// waits while that register still holds an untaken result. One beat is in
// work at a time; a waiting result does not block the next item's walk.
// ----------------------------------------------------------------------------
module trie_word_store
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  tws_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output tws_result_t result
);

    tws_cmd_t  cmd;
    tws_stat_t stat;

    tws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    tws_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* rtl/tws_ctrl.sv */
// ----------------------------------------------------------------------------
// tws_ctrl - sequencer of the trie word store
// Runs the clearing pass after reset, then takes one letter beat at a time
// through lookup, optional end-of-word step and result hand-off.
// ----------------------------------------------------------------------------
module tws_ctrl
    import tws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  tws_stat_t stat,
    output tws_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.item_last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Accept beats only while idle
    assign item_stall = (state_reg != ST_IDLE);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/tws_datapath.sv */
// ----------------------------------------------------------------------------
// tws_datapath - node memories and walk registers of the trie word store
// Holds the child-link row memory, the end-mark memory, the current node,
// the free-node counter, the word flags and the result register.
// ----------------------------------------------------------------------------
module tws_datapath
    import tws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tws_cmd_t    cmd,
    output tws_stat_t   stat,
    input  tws_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output tws_result_t result
);

    // Memories
    tws_row_t link_mem [MAX_NODES];
    logic     end_mem  [MAX_NODES];

    // Payload registers
    tws_item_t   item_reg;
    tws_row_t    row_reg;
    logic        end_rd_reg;
    tws_result_t result_reg;

    // Control registers
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] cur_next;
    logic [FREE_W-1:0] free_reg;
    logic              missed_reg;
    logic              over_reg;
    logic [NODE_W-1:0] clr_cnt_reg;
    logic              result_valid_reg;

    // Walk decode
    logic [LINK_IDX_W-1:0] idx;
    logic [NODE_W-1:0]     link;
    logic                  active;
    logic                  has_link;
    logic                  is_insert;
    logic                  room;
    logic                  step;
    logic                  alloc;
    logic                  lost;
    logic                  end_write;
    logic                  link_we;
    logic [NODE_W-1:0]     link_wa;
    tws_row_t              link_wd;
    logic                  end_we;
    logic [NODE_W-1:0]     end_wa;
    logic                  end_wd;
    tws_result_t           result_next;

    assign idx       = item_reg.letter[LINK_IDX_W-1:0];
    assign link      = row_reg[idx];
    assign active    = !missed_reg && !over_reg
                       && (item_reg.letter < LETTER_W'(ALPHABET_SIZE));
    assign has_link  = (link != '0);
    assign is_insert = (item_reg.command == CMD_INSERT);
    assign room      = (free_reg < FREE_W'(MAX_NODES));
    assign step      = active && has_link;
    assign alloc     = active && !has_link && is_insert && room;
    assign lost      = missed_reg || over_reg;
    assign end_write = cmd.finish_load && is_insert && !lost;

    // Select the node the walk moves to
    always_comb
    begin
        priority if (cmd.finish_load)
        begin
            cur_next = '0;
        end
        else if (cmd.exec && step)
        begin
            cur_next = link;
        end
        else if (cmd.exec && alloc)
        begin
            cur_next = free_reg[NODE_W-1:0];
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    // Build memory writes: clearing pass, link allocation or end-mark set
    always_comb
    begin
        link_wd = row_reg;
        link_wd[idx] = free_reg[NODE_W-1:0];
        if (cmd.clear_step)
        begin
            link_wd = '0;
        end
        link_we = cmd.clear_step || (cmd.exec && alloc);
        link_wa = cmd.clear_step ? clr_cnt_reg : cur_reg;
        end_we  = cmd.clear_step || end_write;
        end_wa  = cmd.clear_step ? clr_cnt_reg : cur_reg;
        end_wd  = !cmd.clear_step;
    end

    // Form the result of a finished word
    always_comb
    begin
        result_next.pool_full = over_reg;
        priority if (is_insert)
        begin
            result_next.found = !lost;
        end
        else if (item_reg.command == CMD_SEARCH)
        begin
            result_next.found = !lost && end_rd_reg;
        end
        else
        begin
            result_next.found = !lost;
        end
    end

    // Link row memory, read on accept
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.accept)
        begin
            row_reg <= link_mem[cur_reg];
        end
    end

    // End-mark memory, read at the node the walk moves to
    always_ff @(posedge clk)
    begin
        if (end_we)
        begin
            end_mem[end_wa] <= end_wd;
        end
        end_rd_reg <= end_mem[cur_next];
    end

    // Latch the accepted beat and the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.finish_load)
        begin
            result_reg <= result_next;
        end
    end

    // Advance walk state, free counter, clear counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg          <= '0;
            free_reg         <= FREE_W'(1);
            missed_reg       <= 1'b0;
            over_reg         <= 1'b0;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            end
            if (cmd.exec && alloc)
            begin
                free_reg <= free_reg + FREE_W'(1);
            end
            if (cmd.finish_load)
            begin
                missed_reg <= 1'b0;
                over_reg   <= 1'b0;
            end
            else if (cmd.exec && active && !has_link)
            begin
                if (!is_insert)
                begin
                    missed_reg <= 1'b1;
                end
                else if (!room)
                begin
                    over_reg <= 1'b1;
                end
            end
            if (cmd.finish_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == NODE_W'(MAX_NODES - 1));
    assign stat.item_last  = item_reg.last_letter;
    assign stat.out_free   = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The current node is always an allocated node
    a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < free_reg)
        else $error("current node beyond allocated pool");

    // An allocation takes exactly one node from the pool
    a_alloc_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && alloc) |=> (free_reg == $past(free_reg) + FREE_W'(1)))
        else $error("free counter did not advance by one");

    // Overflow only happens with the pool exhausted
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> (free_reg == FREE_W'(MAX_NODES)))
        else $error("overflow flagged with free nodes left");

    // A delivered word returns the walk to the root with clean flags
    a_word_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_load |=> (cur_reg == '0 && !missed_reg && !over_reg
                             && result_valid_reg))
        else $error("walk not reset after word result");

endmodule
